>>> design/mshm_pkg.sv
// shared widths, codes and record types of the heartbeat monitor
package mshm_pkg;

    localparam int NUM_SOURCES_DEF   = 16;
    localparam int MAX_FAULT_REPORTS = 16;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 24;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        K_REGISTER = 3'd0,
        K_KICK     = 3'd1,
        K_SET_BUSY = 3'd2,
        K_QUERY    = 3'd3,
        K_TICK     = 3'd4,
        K_SWEEP    = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_SOURCE = 2'd2
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     source_id;
        logic [PERIOD_W-1:0] new_period;
        logic                busy_value;
    } t_item;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   kick_time;
        logic                busy;
        logic                stale;
        logic [CNT_W-1:0]    episodes;
    } t_slot_rec;

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     slot;
        logic [PERIOD_W-1:0] period_out;
        logic [TIME_W-1:0]   age;
        logic                busy_out;
        logic                stale_out;
        logic [CNT_W-1:0]    episode_count;
        logic                fault_report;
        logic                all_fresh;
        logic                feed_watchdog;
        logic [CNT_W-1:0]    fault_total;
        logic                last;
    } t_result;

    typedef struct packed {
        logic latch;
        logic tick;
        logic rd_id;
        logic rd_idx;
        logic idx_inc;
        logic item_wr;
        logic reg_emit;
        logic query_emit;
        logic sw_eval;
        logic sum_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_used;
        logic idx_last;
        logic sw_new;
        logic rep_room;
        logic out_free;
    } t_dp_stat;

endpackage

>>> design/mshm_intf.sv
// request, result and configuration channels of the heartbeat monitor
interface mshm_req_if;
    logic                              valid;
    logic                              ready;
    logic [mshm_pkg::KIND_W-1:0]       kind;
    logic [mshm_pkg::ID_W-1:0]         source_id;
    logic [mshm_pkg::PERIOD_W-1:0]     new_period;
    logic                              busy_value;

    modport source (output valid, kind, source_id, new_period, busy_value, input ready);
    modport sink   (input valid, kind, source_id, new_period, busy_value, output ready);
endinterface

interface mshm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [mshm_pkg::STATUS_W-1:0]     status;
    logic [mshm_pkg::ID_W-1:0]         slot;
    logic [mshm_pkg::PERIOD_W-1:0]     period_out;
    logic [mshm_pkg::TIME_W-1:0]       age;
    logic                              busy_out;
    logic                              stale_out;
    logic [mshm_pkg::CNT_W-1:0]        episode_count;
    logic                              fault_report;
    logic                              all_fresh;
    logic                              feed_watchdog;
    logic [mshm_pkg::CNT_W-1:0]        fault_total;
    logic                              last;

    modport source (output valid, status, slot, period_out, age, busy_out, stale_out,
                    episode_count, fault_report, all_fresh, feed_watchdog, fault_total,
                    last, input ready);
    modport sink   (input valid, status, slot, period_out, age, busy_out, stale_out,
                    episode_count, fault_report, all_fresh, feed_watchdog, fault_total,
                    last, output ready);
endinterface

interface mshm_cfg_if;
    logic valid;
    logic ready;
    logic watchdog_armed;

    modport source (output valid, watchdog_armed, input ready);
    modport sink   (input valid, watchdog_armed, output ready);
endinterface

>>> design/mshm_datapath.sv
// slot memory, counters, staleness compare and result register
module mshm_datapath #(
    parameter int NUM_SOURCES = mshm_pkg::NUM_SOURCES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mshm_pkg::t_item     i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_armed,
    input  mshm_pkg::t_dp_cmd   i_cmd,
    output mshm_pkg::t_dp_stat  o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mshm_pkg::t_result   o_out
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int REP_W = $clog2(mshm_pkg::MAX_FAULT_REPORTS + 1);

    mshm_pkg::t_slot_rec              r_mem [NUM_SOURCES];
    mshm_pkg::t_slot_rec              r_rd;
    mshm_pkg::t_item                  r_item;
    mshm_pkg::t_result                r_out;
    logic [NUM_SOURCES-1:0]           r_used;
    logic [IDX_W-1:0]                 r_idx;
    logic [mshm_pkg::TIME_W-1:0]      r_uptime;
    logic [mshm_pkg::CNT_W-1:0]       r_total;
    logic                             r_armed;
    logic                             r_fresh;
    logic [REP_W-1:0]                 r_nrep;
    logic                             r_out_valid;

    logic [mshm_pkg::CNT_W-1:0]       n_total;
    mshm_pkg::t_result                n_res;
    logic                             n_emit;

    logic [IDX_W-1:0]                 id_addr;
    logic                             id_ok;
    logic                             id_used;
    logic                             idx_used;
    logic [mshm_pkg::TIME_W-1:0]      age;
    logic                             sw_hit;
    logic                             sw_new;
    logic                             rep_room;
    logic                             fault_emit;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [IDX_W-1:0]                 rd_addr;
    mshm_pkg::t_slot_rec              wr_rec;

    assign id_addr    = IDX_W'(r_item.source_id);
    assign id_ok      = (int'(r_item.source_id) < NUM_SOURCES);
    assign id_used    = id_ok && r_used[id_addr];
    assign idx_used   = r_used[r_idx];
    assign age        = r_uptime - r_rd.kick_time;
    assign sw_hit     = idx_used && r_rd.busy && (age > mshm_pkg::TIME_W'(r_rd.period));
    assign sw_new     = sw_hit && !r_rd.stale;
    assign rep_room   = (r_nrep < REP_W'(mshm_pkg::MAX_FAULT_REPORTS));
    assign fault_emit = i_cmd.sw_eval && sw_new && rep_room;
    assign rd_addr    = i_cmd.rd_id ? id_addr : r_idx;
    assign n_total    = r_total + mshm_pkg::CNT_W'(i_cmd.sw_eval && sw_new);
    assign n_emit     = i_cmd.reg_emit || i_cmd.query_emit || fault_emit || i_cmd.sum_emit;

    assign o_stat.idx_used = idx_used;
    assign o_stat.idx_last = (r_idx == IDX_W'(NUM_SOURCES - 1));
    assign o_stat.sw_new   = sw_new;
    assign o_stat.rep_room = rep_room;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // slot record update
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_rec  = r_rd;
        if (i_cmd.item_wr) begin
            wr_addr = id_addr;
            wr_en   = id_ok;
            if (r_item.kind == mshm_pkg::K_KICK) begin
                wr_rec.kick_time = r_uptime;
                wr_rec.stale     = 1'b0;
            end else begin
                wr_rec.busy = r_item.busy_value;
                if (r_item.busy_value) begin
                    wr_rec.kick_time = r_uptime;
                end
            end
        end else if (i_cmd.reg_emit) begin
            wr_en            = !idx_used;
            wr_rec.period    = r_item.new_period;
            wr_rec.kick_time = r_uptime;
            wr_rec.busy      = 1'b1;
            wr_rec.stale     = 1'b0;
            wr_rec.episodes  = '0;
        end else if (i_cmd.sw_eval) begin
            wr_en           = sw_new;
            wr_rec.stale    = 1'b1;
            wr_rec.episodes = r_rd.episodes + 1'b1;
        end
    end

    // result formation
    always_comb begin
        n_res             = '0;
        n_res.status      = mshm_pkg::ST_OK;
        n_res.fault_total = n_total;
        if (i_cmd.reg_emit) begin
            n_res.last = 1'b1;
            if (idx_used) begin
                n_res.status = mshm_pkg::ST_FULL;
            end else begin
                n_res.slot       = mshm_pkg::ID_W'(r_idx);
                n_res.period_out = r_item.new_period;
                n_res.busy_out   = 1'b1;
            end
        end else if (i_cmd.query_emit) begin
            n_res.last = 1'b1;
            if (id_used) begin
                n_res.slot          = r_item.source_id;
                n_res.period_out    = r_rd.period;
                n_res.age           = age;
                n_res.busy_out      = r_rd.busy;
                n_res.stale_out     = r_rd.stale;
                n_res.episode_count = r_rd.episodes;
            end else begin
                n_res.status = mshm_pkg::ST_NO_SOURCE;
            end
        end else if (i_cmd.sw_eval) begin
            n_res.slot          = mshm_pkg::ID_W'(r_idx);
            n_res.period_out    = r_rd.period;
            n_res.age           = age;
            n_res.busy_out      = 1'b1;
            n_res.stale_out     = 1'b1;
            n_res.episode_count = r_rd.episodes + 1'b1;
            n_res.fault_report  = 1'b1;
        end else if (i_cmd.sum_emit) begin
            n_res.all_fresh     = r_fresh;
            n_res.feed_watchdog = r_fresh && r_armed;
            n_res.last          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_idx       <= '0;
            r_uptime    <= '0;
            r_total     <= '0;
            r_armed     <= 1'b0;
            r_fresh     <= 1'b1;
            r_nrep      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_armed <= i_cfg_armed;
            end
            if (i_cmd.tick) begin
                r_uptime <= r_uptime + 1'b1;
            end
            r_total <= n_total;
            if (i_cmd.reg_emit && !idx_used) begin
                r_used[r_idx] <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_idx   <= '0;
                r_fresh <= 1'b1;
                r_nrep  <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.sw_eval && sw_hit) begin
                r_fresh <= 1'b0;
            end
            if (fault_emit) begin
                r_nrep <= r_nrep + 1'b1;
            end
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (n_emit) begin
            r_out <= n_res;
        end
    end

    // slot memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_rec;
        end
        if (i_cmd.rd_id || i_cmd.rd_idx) begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

>>> design/mshm_ctrl.sv
// sequencer for register scan, read-modify-write, query and check sweep
module mshm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic [mshm_pkg::KIND_W-1:0]   i_req_kind,
    output logic                          o_req_ready,
    input  mshm_pkg::t_dp_stat            i_stat,
    output mshm_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REG_SCAN,
        S_REG_EMIT,
        S_RMW_RD,
        S_RMW_WR,
        S_Q_RD,
        S_Q_EMIT,
        S_SW_RD,
        S_SW_EVAL,
        S_SW_SUM
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (mshm_pkg::t_kind'(i_req_kind))
                        mshm_pkg::K_REGISTER: n_state = S_REG_SCAN;
                        mshm_pkg::K_KICK,
                        mshm_pkg::K_SET_BUSY: n_state = S_RMW_RD;
                        mshm_pkg::K_QUERY:    n_state = S_Q_RD;
                        mshm_pkg::K_TICK:     o_cmd.tick = 1'b1;
                        mshm_pkg::K_SWEEP:    n_state = S_SW_RD;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_REG_SCAN: begin
                if (!i_stat.idx_used || i_stat.idx_last) begin
                    n_state = S_REG_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_REG_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.reg_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RMW_RD: begin
                o_cmd.rd_id = 1'b1;
                n_state     = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.item_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_Q_RD: begin
                o_cmd.rd_id = 1'b1;
                n_state     = S_Q_EMIT;
            end
            S_Q_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.query_emit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SW_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_SW_EVAL;
            end
            S_SW_EVAL: begin
                // hold while a fault request waits for the result register
                if (!(i_stat.sw_new && i_stat.rep_room && !i_stat.out_free)) begin
                    o_cmd.sw_eval = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_SW_SUM;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_SW_RD;
                    end
                end
            end
            S_SW_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.sum_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> design/multi_source_heartbeat_monitor_core.sv
// top level of the multi-source heartbeat monitor
// Heartbeat monitor for up to NUM_SOURCES software sources, one request at a
// time. Slot records sit in a memory with a registered read, and each request
// walks it one slot access at a time: a tick advances the uptime, a kick or
// set-busy reads the slot and writes it back, a query reads the slot and
// emits its result, a register scans past each occupied slot ahead of the
// first free one and emits, and a check sweep reads and evaluates each slot,
// reporting new faults, then emits a summary. A step that emits a result
// waits while the consumer still holds the result register. A result waiting
// to be taken does not block the next request. The watchdog_armed register
// may be written at any time and takes effect on the next sweep summary.
module multi_source_heartbeat_monitor_core #(
    parameter int NUM_SOURCES = mshm_pkg::NUM_SOURCES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mshm_req_if.sink    i_req,
    mshm_rsp_if.source  o_rsp,
    mshm_cfg_if.sink    i_cfg
);

    mshm_pkg::t_item     w_item;
    mshm_pkg::t_dp_cmd   w_cmd;
    mshm_pkg::t_dp_stat  w_stat;
    mshm_pkg::t_result   w_out;
    logic                w_out_valid;
    logic                w_req_ready;

    assign w_item.kind       = i_req.kind;
    assign w_item.source_id  = i_req.source_id;
    assign w_item.new_period = i_req.new_period;
    assign w_item.busy_value = i_req.busy_value;

    assign i_req.ready = w_req_ready;
    assign i_cfg.ready = 1'b1;

    mshm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.kind),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mshm_datapath #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_armed (i_cfg.watchdog_armed),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign o_rsp.valid         = w_out_valid;
    assign o_rsp.status        = w_out.status;
    assign o_rsp.slot          = w_out.slot;
    assign o_rsp.period_out    = w_out.period_out;
    assign o_rsp.age           = w_out.age;
    assign o_rsp.busy_out      = w_out.busy_out;
    assign o_rsp.stale_out     = w_out.stale_out;
    assign o_rsp.episode_count = w_out.episode_count;
    assign o_rsp.fault_report  = w_out.fault_report;
    assign o_rsp.all_fresh     = w_out.all_fresh;
    assign o_rsp.feed_watchdog = w_out.feed_watchdog;
    assign o_rsp.fault_total   = w_out.fault_total;
    assign o_rsp.last          = w_out.last;

endmodule

>>> design/mshm_checker.sv
// port-level assertions on the result channel, bound to the top level
module mshm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [mshm_pkg::STATUS_W-1:0] i_status,
    input logic                          i_busy_out,
    input logic                          i_stale_out,
    input logic                          i_fault_report,
    input logic                          i_all_fresh,
    input logic                          i_feed_watchdog,
    input logic [mshm_pkg::CNT_W-1:0]    i_fault_total,
    input logic                          i_last
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_last)
            && $stable(i_fault_total))
        else $error("stalled result changed");

    a_fault_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_fault_report |-> (i_status == mshm_pkg::ST_OK) && !i_last
            && i_stale_out && i_busy_out && !i_all_fresh && !i_feed_watchdog)
        else $error("malformed fault result");

    a_feed_needs_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_feed_watchdog |-> i_all_fresh && i_last && !i_fault_report)
        else $error("feed without a clean summary");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != mshm_pkg::ST_OK) |-> i_last && !i_fault_report)
        else $error("error status on a non-final result");

endmodule

bind multi_source_heartbeat_monitor_core mshm_checker u_mshm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_rsp.valid),
    .i_ready         (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_busy_out      (o_rsp.busy_out),
    .i_stale_out     (o_rsp.stale_out),
    .i_fault_report  (o_rsp.fault_report),
    .i_all_fresh     (o_rsp.all_fresh),
    .i_feed_watchdog (o_rsp.feed_watchdog),
    .i_fault_total   (o_rsp.fault_total),
    .i_last          (o_rsp.last)
);
